// ===== rtl/core/pdr_pkg.sv =====
package pdr_pkg;

  // Width of the PWM down-counters and of the match and goal values.
  localparam int CNT_W = 16;
  // Width of the ramp prescalers, which restart from zero at the step limit.
  localparam int PRESC_W = 16;
  // Width of each configuration register.
  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 2;

  // Reset values of the configuration registers.
  localparam logic [CFG_W-1:0] PERIOD_RESET = CFG_W'(32500);
  localparam logic [CFG_W-1:0] SCALE_RESET = CFG_W'(325);
  localparam logic [CFG_W-1:0] INTERVAL_RESET = CFG_W'(200);
  // Reload value that follows from the reset period.
  localparam logic [CNT_W-1:0] RELOAD_RESET = CNT_W'(32499);

  typedef enum logic [1:0] {
    KIND_TICK      = 2'd0,
    KIND_SET_SPEED = 2'd1,
    KIND_RAMP      = 2'd2,
    KIND_SET_DIR   = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PERIOD   = 2'd0,
    REG_SCALE    = 2'd1,
    REG_INTERVAL = 2'd2,
    REG_UNUSED   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       channel;
    logic [6:0] speed;
    logic       direction;
  } in_t;

  typedef struct packed {
    logic        left_pwm;
    logic        right_pwm;
    logic        left_dir_pin;
    logic        right_dir_pin;
    logic        left_ramping;
    logic        right_ramping;
    logic [15:0] left_match_now;
    logic [15:0] right_match_now;
  } out_t;

  // Per-transaction command to one channel; at most one of the flags is set.
  typedef struct packed {
    logic               tick;
    logic               set_now;
    logic               ramp;
    logic [CNT_W-1:0]   target;
    logic [CNT_W-1:0]   reload;
    logic [PRESC_W-1:0] limit;
  } ch_cmd_t;

  // Channel status after the transaction has been applied.
  typedef struct packed {
    logic             pwm;
    logic             ramping;
    logic [CNT_W-1:0] match;
  } ch_stat_t;

endpackage

// ===== rtl/core/pdr_channel.sv =====
module pdr_channel (
  input  logic               clk,
  input  logic               rst_n,
  input  pdr_pkg::ch_cmd_t   cmd,
  output pdr_pkg::ch_stat_t  stat
);

  logic [pdr_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [pdr_pkg::CNT_W-1:0]   match_r, match_nxt;
  logic [pdr_pkg::CNT_W-1:0]   goal_r, goal_nxt;
  logic [pdr_pkg::PRESC_W-1:0] presc_r, presc_nxt;
  logic [pdr_pkg::PRESC_W-1:0] presc_inc;

  always_comb begin
    cnt_nxt   = cnt_r;
    match_nxt = match_r;
    goal_nxt  = goal_r;
    presc_nxt = presc_r;
    presc_inc = presc_r + pdr_pkg::PRESC_W'(1);
    if (cmd.tick) begin
      // A counter left above a shortened reload restarts at once.
      if ((cnt_r == '0) || (cnt_r > cmd.reload)) begin
        cnt_nxt = cmd.reload;
      end else begin
        cnt_nxt = cnt_r - pdr_pkg::CNT_W'(1);
      end
      if (match_r == goal_r) begin
        presc_nxt = '0;
      end else if (presc_inc >= cmd.limit) begin
        presc_nxt = '0;
        if (match_r < goal_r) begin
          match_nxt = match_r + pdr_pkg::CNT_W'(1);
        end else begin
          match_nxt = match_r - pdr_pkg::CNT_W'(1);
        end
      end else begin
        presc_nxt = presc_inc;
      end
    end else if (cmd.set_now) begin
      match_nxt = cmd.target;
      goal_nxt  = cmd.target;
      presc_nxt = '0;
    end else if (cmd.ramp) begin
      goal_nxt  = cmd.target;
      presc_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= pdr_pkg::RELOAD_RESET;
      match_r <= pdr_pkg::RELOAD_RESET;
      goal_r  <= pdr_pkg::RELOAD_RESET;
      presc_r <= '0;
    end else begin
      cnt_r   <= cnt_nxt;
      match_r <= match_nxt;
      goal_r  <= goal_nxt;
      presc_r <= presc_nxt;
    end
  end

  assign stat.pwm     = cnt_nxt > match_nxt;
  assign stat.ramping = match_nxt != goal_nxt;
  assign stat.match   = match_nxt;

endmodule

// ===== rtl/core/pwm_duty_ramp_two_channel_top.sv =====
// Channel   Direction  Handshake               Payload
// in_       input      in_valid / in_stall     in_data    (pdr_pkg::in_t)
// out_      output     out_valid / out_stall   out_data   (pdr_pkg::out_t)
// cfg_      input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// A transaction updates the channel state at the edge where it is accepted and
// its result is registered at that edge, in the output register or, if out_stall
// holds it, in the skid entry; one transaction per cycle while in_stall is low.
// The output register is backed by one skid entry, so in_stall rises only
// when both are full and is a registered signal.
// Synchronous active-low reset restores the configuration, counters and pins.
module pwm_duty_ramp_two_channel_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  pdr_pkg::in_t                    in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output pdr_pkg::out_t                   out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pdr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pdr_pkg::CFG_W-1:0]       cfg_data
);

  // Configuration registers. Writes are taken in any cycle.
  logic [pdr_pkg::CFG_W-1:0] period_r, scale_r, interval_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r   <= pdr_pkg::PERIOD_RESET;
      scale_r    <= pdr_pkg::SCALE_RESET;
      interval_r <= pdr_pkg::INTERVAL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (pdr_pkg::cfg_idx_t'(cfg_index))
        pdr_pkg::REG_PERIOD:   period_r   <= cfg_data;
        pdr_pkg::REG_SCALE:    scale_r    <= cfg_data;
        pdr_pkg::REG_INTERVAL: interval_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Shared derived values: reload, step limit and the speed target.
  logic [pdr_pkg::CNT_W-1:0]   reload;
  logic [pdr_pkg::PRESC_W-1:0] limit;
  logic [22:0]                 high_full;
  logic [pdr_pkg::CNT_W-1:0]   high_sat;
  logic [pdr_pkg::CNT_W-1:0]   target;

  always_comb begin
    // A period of zero or one gives a zero reload.
    if (period_r <= pdr_pkg::CFG_W'(1)) begin
      reload = '0;
    end else begin
      reload = pdr_pkg::CNT_W'(period_r - pdr_pkg::CFG_W'(1));
    end
    // A zero ramp interval behaves as one.
    limit = (interval_r == '0) ? pdr_pkg::PRESC_W'(1) : pdr_pkg::PRESC_W'(interval_r);
    // High time saturates at the reload value, the most that the period allows.
    high_full = 23'(in_data.speed) * 23'(scale_r);
    if (high_full > 23'(reload)) begin
      high_sat = reload;
    end else begin
      high_sat = pdr_pkg::CNT_W'(high_full);
    end
    target = reload - high_sat;
  end

  // Output register with one skid entry behind it.
  logic           out_valid_r, out_valid_nxt;
  pdr_pkg::out_t  out_data_r, out_data_nxt;
  logic           skid_valid_r, skid_valid_nxt;
  pdr_pkg::out_t  skid_data_r, skid_data_nxt;
  logic           accept;

  assign in_stall = skid_valid_r;
  assign accept   = in_valid && !skid_valid_r;

  // Decode the transaction into a command for each channel.
  pdr_pkg::kind_t    kind;
  pdr_pkg::ch_cmd_t  cmd_l, cmd_r;
  pdr_pkg::ch_stat_t stat_l, stat_r;

  assign kind = pdr_pkg::kind_t'(in_data.kind);

  always_comb begin
    cmd_l.tick    = accept && (kind == pdr_pkg::KIND_TICK);
    cmd_l.set_now = accept && (kind == pdr_pkg::KIND_SET_SPEED) && !in_data.channel;
    cmd_l.ramp    = accept && (kind == pdr_pkg::KIND_RAMP) && !in_data.channel;
    cmd_l.target  = target;
    cmd_l.reload  = reload;
    cmd_l.limit   = limit;
    cmd_r         = cmd_l;
    cmd_r.set_now = accept && (kind == pdr_pkg::KIND_SET_SPEED) && in_data.channel;
    cmd_r.ramp    = accept && (kind == pdr_pkg::KIND_RAMP) && in_data.channel;
  end

  pdr_channel u_left (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd_l),
    .stat  (stat_l)
  );

  pdr_channel u_right (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd_r),
    .stat  (stat_r)
  );

  // Direction pins: the left pin follows the direction bit, the right pin
  // is its inverse, so each is high for its own polarity.
  logic [1:0] dir_r, dir_nxt;

  always_comb begin
    dir_nxt = dir_r;
    if (accept && (kind == pdr_pkg::KIND_SET_DIR)) begin
      if (!in_data.channel) begin
        dir_nxt[0] = in_data.direction;
      end else begin
        dir_nxt[1] = !in_data.direction;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r <= '0;
    end else begin
      dir_r <= dir_nxt;
    end
  end

  // Result of the accepted transaction, taken from the updated state.
  pdr_pkg::out_t result;

  always_comb begin
    result.left_pwm        = stat_l.pwm;
    result.right_pwm       = stat_r.pwm;
    result.left_dir_pin    = dir_nxt[0];
    result.right_dir_pin   = dir_nxt[1];
    result.left_ramping    = stat_l.ramping;
    result.right_ramping   = stat_r.ramping;
    result.left_match_now  = stat_l.match;
    result.right_match_now = stat_r.match;
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || !out_stall) begin
      // The output register is free this cycle; the skid entry goes first.
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = accept;
        out_data_nxt  = result;
      end
    end else if (accept) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
